// File: design/ssa_pkg.sv
// Shared types and constants for the sparse set id allocator.
// Used by the control unit, both memories and the top level; no dependencies.
`timescale 1ns / 1ps

package ssa_pkg;

	// Capacity and derived widths
	localparam int MAX_IDS = 1024;
	localparam int ID_W    = $clog2(MAX_IDS);
	localparam int CNT_W   = $clog2(MAX_IDS + 1);

	// Map entry marking an id that is not active
	localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(MAX_IDS);
	localparam logic [CNT_W-1:0] POS_INVALID = MAX_CNT;

	// Command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_INACTIVE = 2'd2;

	// Access request to the id store (dense list low, recycle stack high)
	typedef struct packed {
		logic            we;
		logic [ID_W-1:0] waddr;
		logic [ID_W-1:0] wdata;
		logic            re;
		logic [ID_W-1:0] raddr;
	} store_req_t;

	// Access request to the position map
	typedef struct packed {
		logic             we;
		logic [ID_W-1:0]  waddr;
		logic [CNT_W-1:0] wdata;
		logic             re;
		logic [ID_W-1:0]  raddr;
	} map_req_t;

endpackage

// File: design/ssa_id_store.sv
// Id store: one memory holding the dense list from the bottom and the
// recycle stack from the top. Depends on ssa_pkg.
`timescale 1ns / 1ps

module ssa_id_store (
	input  logic                   clk,
	input  ssa_pkg::store_req_t    req,
	output logic [ssa_pkg::ID_W-1:0] rdata
);
	import ssa_pkg::*;

	logic [ID_W-1:0] mem [MAX_IDS];
	logic [ID_W-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ssa_pos_map.sv
// Position map: dense position of each id, or the invalid marker.
// Depends on ssa_pkg.
`timescale 1ns / 1ps

module ssa_pos_map (
	input  logic                    clk,
	input  ssa_pkg::map_req_t       req,
	output logic [ssa_pkg::CNT_W-1:0] rdata
);
	import ssa_pkg::*;

	logic [CNT_W-1:0] mem [MAX_IDS];
	logic [CNT_W-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ssa_ctrl.sv
// Control unit: command sequencer, counters and output word register.
// Depends on ssa_pkg; drives ssa_id_store and ssa_pos_map.
`timescale 1ns / 1ps

module ssa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [ssa_pkg::ID_W-1:0]  target_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ssa_pkg::ID_W-1:0]  granted_id,
	output logic [1:0]                status,
	output logic [ssa_pkg::CNT_W-1:0] active_count,
	output ssa_pkg::store_req_t       store_req,
	input  logic [ssa_pkg::ID_W-1:0]  store_rdata,
	output ssa_pkg::map_req_t         map_req,
	input  logic [ssa_pkg::CNT_W-1:0] map_rdata
);
	import ssa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]       state_q, state_d;
	logic             cmd_q;
	logic [ID_W-1:0]  tid_q;
	logic [CNT_W-1:0] live_q, live_d;
	logic [CNT_W-1:0] depth_q, depth_d;
	logic [CNT_W-1:0] fresh_q, fresh_d;

	logic             out_valid_q;
	logic [ID_W-1:0]  granted_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             out_free;
	logic             res_fire;
	logic [ID_W-1:0]  res_id;
	logic [1:0]       res_status;
	logic [CNT_W-1:0] res_count;
	logic             alloc_full;
	logic [ID_W-1:0]  alloc_id;
	logic             free_ok;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Allocation source: top of recycle stack, else fresh counter
	assign alloc_full = (live_q >= MAX_CNT) || ((depth_q == '0) && (fresh_q >= MAX_CNT));
	assign alloc_id   = (depth_q != '0) ? store_rdata : fresh_q[ID_W-1:0];

	// Ids at or above the fresh counter were never written: read as invalid
	assign free_ok = (CNT_W'(tid_q) < fresh_q) && (map_rdata < live_q);

	// Sequencer, memory requests and counter updates
	always_comb begin
		state_d    = state_q;
		live_d     = live_q;
		depth_d    = depth_q;
		fresh_d    = fresh_q;
		res_fire   = 1'b0;
		res_id     = '0;
		res_status = STAT_OK;
		res_count  = live_q;
		store_req  = '0;
		map_req    = '0;
		case (state_q)
			S_IDLE: begin
				// issue both reads as the word is taken
				store_req.re    = accept;
				store_req.raddr = (command == CMD_FREE) ? live_q[ID_W-1:0] - 1'b1
				                                        : ID_W'(MAX_CNT - depth_q);
				map_req.re      = accept;
				map_req.raddr   = target_id;
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd_q == CMD_ALLOC) begin
					if (out_free) begin
						res_fire = 1'b1;
						state_d  = S_IDLE;
						if (alloc_full) begin
							res_status = STAT_FULL;
						end else begin
							store_req.we    = 1'b1;
							store_req.waddr = live_q[ID_W-1:0];
							store_req.wdata = alloc_id;
							map_req.we      = 1'b1;
							map_req.waddr   = alloc_id;
							map_req.wdata   = live_q;
							live_d          = live_q + 1'b1;
							if (depth_q != '0) begin
								depth_d = depth_q - 1'b1;
							end else begin
								fresh_d = fresh_q + 1'b1;
							end
							res_id    = alloc_id;
							res_count = live_q + 1'b1;
						end
					end
				end else if (!free_ok) begin
					if (out_free) begin
						res_fire   = 1'b1;
						res_status = STAT_INACTIVE;
						state_d    = S_IDLE;
					end
				end else begin
					// move the back entry into the hole
					store_req.we    = 1'b1;
					store_req.waddr = map_rdata[ID_W-1:0];
					store_req.wdata = store_rdata;
					map_req.we      = 1'b1;
					map_req.waddr   = store_rdata;
					map_req.wdata   = map_rdata;
					state_d         = S_FIN;
				end
			end
			S_FIN: begin
				// invalidate freed id and push it on the stack
				if (out_free) begin
					map_req.we      = 1'b1;
					map_req.waddr   = tid_q;
					map_req.wdata   = POS_INVALID;
					store_req.we    = 1'b1;
					store_req.waddr = ID_W'(MAX_CNT - 1'b1 - depth_q);
					store_req.wdata = tid_q;
					live_d          = live_q - 1'b1;
					depth_d         = depth_q + 1'b1;
					res_fire        = 1'b1;
					res_count       = live_q - 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			depth_q     <= '0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			live_q  <= live_d;
			depth_q <= depth_d;
			fresh_q <= fresh_d;
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command capture and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			tid_q <= target_id;
		end
		if (res_fire) begin
			granted_q <= res_id;
			status_q  <= res_status;
			count_q   <= res_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_id   = granted_q;
	assign status       = status_q;
	assign active_count = count_q;

endmodule

// File: design/sparse_set_id_allocator.sv
// Sparse set id allocator: allocate takes the last freed id or a fresh one,
// free swap-removes from the dense list. Allocate and error words are issued
// from the execute state, a good free from the finish state after it; a new
// word is taken only once the sequencer is back in idle, as set by the
// read-then-write sequence on the position map and id store ports.
// Reset clears state and counters, not memories; unissued ids read as inactive.
`timescale 1ns / 1ps

module sparse_set_id_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [ssa_pkg::ID_W-1:0]  target_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ssa_pkg::ID_W-1:0]  granted_id,
	output logic [1:0]                status,
	output logic [ssa_pkg::CNT_W-1:0] active_count
);
	import ssa_pkg::*;

	store_req_t       store_req;
	map_req_t         map_req;
	logic [ID_W-1:0]  store_rdata;
	logic [CNT_W-1:0] map_rdata;

	// Sequencer and counters
	ssa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.target_id    (target_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_id   (granted_id),
		.status       (status),
		.active_count (active_count),
		.store_req    (store_req),
		.store_rdata  (store_rdata),
		.map_req      (map_req),
		.map_rdata    (map_rdata)
	);

	// Dense list and recycle stack
	ssa_id_store u_store (
		.clk   (clk),
		.req   (store_req),
		.rdata (store_rdata)
	);

	// Id to dense position map
	ssa_pos_map u_map (
		.clk   (clk),
		.req   (map_req),
		.rdata (map_rdata)
	);

endmodule

// File: design/ssa_checker.sv
// Port-level checks for the sparse set id allocator, bound to the top level.
// Depends on ssa_pkg.
`timescale 1ns / 1ps

module ssa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      command,
	input logic [ssa_pkg::ID_W-1:0]  target_id,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [ssa_pkg::ID_W-1:0]  granted_id,
	input logic [1:0]                status,
	input logic [ssa_pkg::CNT_W-1:0] active_count
);
	import ssa_pkg::*;

	// A taken word keeps the input side busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a word");

	// Only a good allocate hands out a nonzero id
	a_id_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK) |-> (granted_id == '0))
		else $error("id given with an error status");

	// Full is only reported with every id active
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_FULL) |-> (active_count == MAX_CNT))
		else $error("full reported below capacity");

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(granted_id)
			&& $stable(status) && $stable(active_count)))
		else $error("stalled output word changed");

endmodule

bind sparse_set_id_allocator ssa_checker u_ssa_checker (.*);
